// ===== design/grr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grr_pkg
// Shared types and constants of the group reversal reorder buffer.
// ----------------------------------------------------------------------------
package grr_pkg;

  localparam int MAX_GROUP = 16;
  localparam int ADDR_W    = $clog2(MAX_GROUP);
  localparam int CNT_W     = $clog2(MAX_GROUP + 1);
  localparam int VALUE_W   = 32;
  localparam int GSIZE_W   = 5;

  localparam logic [GSIZE_W-1:0] GSIZE_RESET = GSIZE_W'(2);

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      list_end;
  } grr_in_beat_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] out_value;
    logic                      run_last;
    logic                      out_list_end;
  } grr_out_beat_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } grr_state_t;

endpackage

// ===== design/group_reversal_reorder_buffer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// group_reversal_reorder_buffer
// Buffers a stream of values and emits each complete group reversed.
// ----------------------------------------------------------------------------
// Values arrive one per beat and are written into a 16-entry group store at
// the current fill position. When the fill reaches the configured group size
// the whole group is read back newest first; when list_end arrives on an
// incomplete group the buffered values are read back oldest first. Readout
// runs through the single read port of the store, one entry per cycle while
// the output is not stalled, into the output register, and the input is
// stalled while the readout runs. The last beat of a group may sit in the
// output register while the next value is accepted. A group size of 0 behaves
// as 1, one above 16 as 16. Lowering the group size mid-group flushes
// everything buffered, reversed, on the next value that reaches the new size.
// Write group_size only while the block is idle; it resets to 2.
// ----------------------------------------------------------------------------
module group_reversal_reorder_buffer
  import grr_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [GSIZE_W-1:0]  cfg_wr_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  grr_in_beat_t        in_beat,
  output logic                out_valid,
  input  logic                out_stall,
  output grr_out_beat_t       out_beat
);

  // group store: written on input beats, read during readout
  logic [VALUE_W-1:0] mem [MAX_GROUP];

  logic [GSIZE_W-1:0] group_size_r;
  grr_state_t         state_r, state_nxt;
  logic [ADDR_W-1:0]  fill_r, fill_nxt;
  logic [CNT_W-1:0]   rem_r, rem_nxt;
  logic [ADDR_W-1:0]  addr_r, addr_nxt;
  logic               rev_r, rev_nxt;
  logic               end_r, end_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0] rd_data_r;
  logic               run_last_r;
  logic               list_end_r;

  logic [CNT_W-1:0]   k_eff;
  logic [CNT_W-1:0]   n_new;
  logic               in_acc;
  logic               issue;
  logic               full_group;

  // clamp the group size to 1..MAX_GROUP
  always_comb begin
    if (group_size_r == '0) begin
      k_eff = CNT_W'(1);
    end else if (int'(group_size_r) > MAX_GROUP) begin
      k_eff = CNT_W'(MAX_GROUP);
    end else begin
      k_eff = CNT_W'(group_size_r);
    end
  end

  assign in_stall   = (state_r != ST_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign n_new      = CNT_W'(fill_r) + CNT_W'(1);
  assign full_group = (n_new >= k_eff);
  // advance the readout only when the output register is free or draining
  assign issue      = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_size_r <= GSIZE_RESET;
    end else if (cfg_wr_en) begin
      group_size_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mem[fill_r] <= in_beat.value;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data_r <= mem[addr_r];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    rem_nxt       = rem_r;
    addr_nxt      = addr_r;
    rev_nxt       = rev_r;
    end_nxt       = end_r;
    out_valid_nxt = out_valid_r;
    if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (full_group || in_beat.list_end) begin
            state_nxt = ST_EMIT;
            fill_nxt  = '0;
            rem_nxt   = n_new;
            rev_nxt   = full_group;
            addr_nxt  = full_group ? fill_r : '0;
            end_nxt   = in_beat.list_end;
          end else begin
            fill_nxt = fill_r + ADDR_W'(1);
          end
        end
      end
      ST_EMIT: begin
        if (issue) begin
          out_valid_nxt = 1'b1;
          rem_nxt       = rem_r - CNT_W'(1);
          addr_nxt      = rev_r ? (addr_r - ADDR_W'(1)) : (addr_r + ADDR_W'(1));
          if (rem_r == CNT_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers: no reset
  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    rev_r  <= rev_nxt;
    end_r  <= end_nxt;
    if (issue) begin
      run_last_r <= (rem_r == CNT_W'(1));
      list_end_r <= (rem_r == CNT_W'(1)) && end_r;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_beat.out_value     = rd_data_r;
  assign out_beat.run_last      = run_last_r;
  assign out_beat.out_list_end  = list_end_r;

endmodule

// ===== design/grr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grr_checker
// Port-level checks of the group reversal reorder buffer.
// ----------------------------------------------------------------------------
module grr_checker
  import grr_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                in_list_end,
  input logic                out_valid,
  input logic                out_stall,
  input grr_out_beat_t       out_beat
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_beat))
    else $error("stalled result beat changed");

  // the end of the reordered list closes a run
  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_beat.out_list_end |-> out_beat.run_last)
    else $error("list end on a beat that is not run last");

  // while a run is still being read out the input is held off
  a_busy_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_beat.run_last |-> in_stall)
    else $error("input accepted in the middle of a run");

  // a list end always starts a readout
  a_end_flushes: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_list_end |=> in_stall)
    else $error("list end did not start a readout");

endmodule

bind group_reversal_reorder_buffer grr_checker u_grr_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .in_list_end (in_beat.list_end),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_beat    (out_beat)
);

// ===== sim/group_reversal_reorder_buffer_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// group_reversal_reorder_buffer_test
// Self-checking bench for the group reversal reorder buffer.
// ----------------------------------------------------------------------------
// Streams lists of values into the block under a range of group sizes,
// including zero, one, the store depth and sizes above it. A scoreboard
// mirrors the group store and fill count. It works out the reordered beats
// that each accepted value releases and compares every beat that leaves the
// block against the oldest one still owed. Both channels idle at random. The
// receiver holds off once for a long stretch so that the block backs up and
// stalls its input.
// ----------------------------------------------------------------------------
module group_reversal_reorder_buffer_test;
  import grr_pkg::*;

  localparam int RANDOM_ITEMS   = 280;
  localparam int SETTLE_CYCLES  = 24;    // longest readout plus output slack
  localparam int HOLD_OFF_CYCLES = 300;  // long receiver hold-off, fills the block
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no beat on either side
  localparam int MAX_REPORTS    = 10;

  localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7fff_ffff;
  localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;

  // --------------------------------------------------------------------------
  // Scoreboard: mirrors the group store and fill count of the block and keeps
  // the reordered beats that are still owed, oldest first.
  // --------------------------------------------------------------------------
  class group_order_scoreboard;
    logic [VALUE_W-1:0]  group_store [MAX_GROUP];
    int unsigned         fill_count;
    logic [GSIZE_W-1:0]  group_size;
    grr_out_beat_t       reordered_q [$];
    int unsigned         errors;

    function new();
      fill_count = 0;
      group_size = GSIZE_RESET;
      errors     = 0;
    endfunction

    function void set_group_size(logic [GSIZE_W-1:0] gs);
      group_size = gs;
    endfunction

    // Zero behaves as one; anything past the store depth saturates.
    function int unsigned group_span();
      if (group_size == '0) return 1;
      if (group_size > MAX_GROUP) return MAX_GROUP;
      return group_size;
    endfunction

    function int unsigned pending();
      return reordered_q.size();
    endfunction

    // Store the value; release the buffered values once the group is full
    // (newest first) or the list ends short (oldest first).
    function void take_value(grr_in_beat_t b);
      int unsigned   span;
      int unsigned   n;
      bit            reversed;
      bit            last;
      grr_out_beat_t r;
      span = group_span();
      if (fill_count < MAX_GROUP) begin
        group_store[fill_count] = b.value;
        fill_count++;
      end
      n        = fill_count;
      reversed = (n >= span);
      if (reversed || b.list_end) begin
        for (int unsigned i = 0; i < n; i++) begin
          last           = (i + 1 == n);
          r.out_value    = reversed ? group_store[n - 1 - i] : group_store[i];
          r.run_last     = last;
          r.out_list_end = last && b.list_end;
          reordered_q.push_back(r);
        end
        fill_count = 0;
      end
    endfunction

    function void note_error(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("ERROR: %s", msg);
    endfunction

    function void check_emitted(grr_out_beat_t got);
      grr_out_beat_t want;
      if (reordered_q.size() == 0) begin
        note_error($sformatf("unexpected beat: value=%0d run_last=%0b list_end=%0b",
                             $signed(got.out_value), got.run_last, got.out_list_end));
        return;
      end
      want = reordered_q.pop_front();
      if (got.out_value !== want.out_value || got.run_last !== want.run_last ||
          got.out_list_end !== want.out_list_end)
        note_error($sformatf({"expected value=%0d run_last=%0b list_end=%0b, ",
                              "got value=%0d run_last=%0b list_end=%0b"},
                             $signed(want.out_value), want.run_last, want.out_list_end,
                             $signed(got.out_value), got.run_last, got.out_list_end));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block connections
  // --------------------------------------------------------------------------
  logic               clk;
  logic               rst_n       = 1'b0;
  logic               cfg_wr_en   = 1'b0;
  logic [GSIZE_W-1:0] cfg_wr_data = '0;
  logic               in_valid    = 1'b0;
  logic               in_stall;
  grr_in_beat_t       in_beat     = '0;
  logic               out_valid;
  logic               out_stall   = 1'b0;
  grr_out_beat_t      out_beat;

  group_order_scoreboard sb;
  bit                    hold_off_req = 1'b0;  // ask the receiver for one long hold-off
  bit                    smooth_list  = 1'b0;  // send the current list without gaps
  int unsigned           quiet_cycles = 0;

  group_reversal_reorder_buffer DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_beat     (in_beat),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_beat    (out_beat)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Random helpers
  // --------------------------------------------------------------------------
  // Mostly back to back, often a short gap, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Lean on the extremes of the value range, otherwise any 32-bit pattern.
  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return VALUE_MAX;
      1:       return VALUE_MIN;
      2:       return '0;
      3:       return -1;
      default: return $urandom;
    endcase
  endfunction

  // Small groups most of the time; zero, one, the store depth and oversize
  // settings now and then.
  function automatic logic [GSIZE_W-1:0] pick_group_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      case ($urandom_range(0, 4))
        0:       return GSIZE_W'(0);
        1:       return GSIZE_W'(1);
        2:       return GSIZE_W'(MAX_GROUP);
        3:       return GSIZE_W'(MAX_GROUP + 1);
        default: return '1;
      endcase
    end
    if (r < 60) return GSIZE_W'($urandom_range(1, 5));
    if (r < 85) return GSIZE_W'($urandom_range(6, MAX_GROUP));
    return GSIZE_W'($urandom_range(MAX_GROUP + 1, 31));
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // Offer one value and hold it until the block takes it. Valid stays high
  // into the next beat when no gap is drawn.
  task automatic send_value(logic signed [VALUE_W-1:0] v, logic last_of_list);
    int gap;
    gap = smooth_list ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_beat.value    <= v;
    in_beat.list_end <= last_of_list;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_list(int len, bit terminate);
    smooth_list = ($urandom_range(0, 4) == 0);
    for (int i = 0; i < len; i++)
      send_value(pick_value(), terminate && (i == len - 1));
    smooth_list = 1'b0;
  endtask

  // Drop valid, then wait for every owed beat plus the readout latency, in
  // case a value that released nothing is still being written.
  task automatic settle_idle();
    in_valid <= 1'b0;
    do begin
      while (sb.pending() != 0) @(posedge clk);
      repeat (SETTLE_CYCLES) @(posedge clk);
    end while (sb.pending() != 0);
  endtask

  task automatic write_group_size(logic [GSIZE_W-1:0] gs);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= gs;
    @(posedge clk);
    sb.set_group_size(gs);
    cfg_wr_en   <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Receiver: alternate stalls and open runs of random length. Honour a
  // hold-off request with one long stall, counted here.
  // --------------------------------------------------------------------------
  initial begin
    int stall_len;
    int run_len;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_len    = HOLD_OFF_CYCLES;
      end else begin
        stall_len = pick_gap();
      end
      if (stall_len > 0) begin
        out_stall <= 1'b1;
        repeat (stall_len) @(posedge clk);
      end
      run_len = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      out_stall <= 1'b0;
      repeat (run_len) @(posedge clk);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor and watchdog: sample both channels at the edge, feed accepted
  // values to the scoreboard, check accepted results, and give up after a
  // long stretch with no beat on either side.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.take_value(in_beat);
      if (out_valid && !out_stall) sb.check_emitted(out_beat);
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int                 sent;
    int                 phase_sent;
    int                 phase_len;
    int                 phase_idx;
    int                 len;
    int unsigned        span;
    logic [GSIZE_W-1:0] gs;

    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Reset size of two: two full groups, the second closing
    // the list, then a one-value list shorter than the group.
    send_value(VALUE_MAX, 1'b0);
    send_value(VALUE_MIN, 1'b0);
    send_value('0, 1'b0);
    send_value(-1, 1'b1);
    send_value(32'sd5, 1'b1);

    // Size zero behaves as pass-through.
    settle_idle();
    write_group_size(GSIZE_W'(0));
    send_value(32'sd11, 1'b0);
    send_value(VALUE_MIN, 1'b0);
    send_value(32'sd13, 1'b1);

    // Size one, explicitly.
    settle_idle();
    write_group_size(GSIZE_W'(1));
    send_value(VALUE_MAX, 1'b0);
    send_value(32'sd22, 1'b1);

    // Oversize setting saturates; a short list comes out in order.
    settle_idle();
    write_group_size('1);
    send_value(32'sd31, 1'b0);
    send_value(-32'sd32, 1'b0);
    send_value(32'sd33, 1'b1);

    // Lower the size mid-group: the next value flushes all four reversed.
    settle_idle();
    write_group_size(GSIZE_W'(4));
    send_value(32'sd41, 1'b0);
    send_value(32'sd42, 1'b0);
    send_value(32'sd43, 1'b0);
    settle_idle();
    write_group_size(GSIZE_W'(2));
    send_value(32'sd44, 1'b0);
    send_value(32'sd45, 1'b1);

    // Random part: phases of lists under fresh group sizes. Most lists end
    // properly; some run on into the next list or across a size change.
    hold_off_req = 1'b1;
    sent         = 0;
    phase_idx    = 0;
    while (sent < RANDOM_ITEMS) begin
      if (phase_idx == 0)      gs = GSIZE_W'(MAX_GROUP);
      else if (phase_idx == 1) gs = GSIZE_W'(MAX_GROUP + 1);
      else                     gs = pick_group_size();
      settle_idle();
      write_group_size(gs);
      span       = sb.group_span();
      phase_len  = $urandom_range(20, 50);
      phase_sent = 0;
      while (phase_sent < phase_len && sent < RANDOM_ITEMS) begin
        if ($urandom_range(0, 9) < 7)
          len = $urandom_range(1, 2 * span + 2);
        else
          len = $urandom_range(1, 40);
        send_list(len, $urandom_range(0, 9) != 0);
        phase_sent += len;
        sent       += len;
      end
      phase_idx++;
    end

    // Drain and give the verdict.
    settle_idle();
    if (sb.errors == 0 && sb.pending() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
